@@ rtl/crs_pkg.sv @@
package crs_pkg;

    localparam int COORD_W    = 32;
    localparam int T_W        = 16;
    localparam int K_W        = 6;
    localparam int STEP_W     = 16;
    localparam int W_W        = 52;
    localparam int H_SHIFT    = 25;
    localparam int H_W        = W_W - H_SHIFT;
    localparam int PROD_W     = H_W + COORD_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int Q_SHIFT    = 24;
    localparam int Q_W        = ACC_W - Q_SHIFT;
    localparam int CFG_DATA_W = 16;

    localparam logic [K_W-1:0]  SAMPLES_RESET = K_W'(16);
    localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(4096);
    localparam logic [T_W-1:0]  T_MAX         = '1;

    localparam logic CFG_SAMPLES = 1'b0;
    localparam logic CFG_STEP    = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // One closed segment: p[0..3] are P[j]..P[j+3].
    typedef struct packed {
        point_t [3:0] p;
        logic         last;
    } job_t;

    typedef struct packed {
        logic [K_W-1:0]    samples;
        logic [STEP_W-1:0] step;
    } cfg_t;

endpackage

@@ rtl/crs_queue.sv @@
module crs_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crs_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          job_valid,
    output crs_pkg::job_t job
);

    crs_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/crs_front.sv @@
module crs_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  crs_pkg::point_t in_point,
    input  logic            in_last,
    input  logic            queue_full,
    output logic            push,
    output crs_pkg::job_t   push_job
);

    crs_pkg::point_t window_reg [3];
    logic [1:0]      seen_reg, seen_next;
    logic            accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    // A segment closes once three earlier points of the curve are held.
    assign push     = accept && (seen_reg == 2'd3);

    always_comb
    begin
        push_job.p[0] = window_reg[0];
        push_job.p[1] = window_reg[1];
        push_job.p[2] = window_reg[2];
        push_job.p[3] = in_point;
        push_job.last = in_last;

        seen_next = seen_reg;
        if (accept)
        begin
            if (in_last)
            begin
                seen_next = 2'd0;
            end
            else if (seen_reg != 2'd3)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg[0] <= '0;
            window_reg[1] <= '0;
            window_reg[2] <= '0;
            seen_reg      <= 2'd0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (accept && !in_last)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= in_point;
            end
        end
    end

endmodule

@@ rtl/crs_back.sv @@
module crs_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  crs_pkg::cfg_t   cfg,
    input  logic            job_valid,
    input  crs_pkg::job_t   job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output crs_pkg::point_t out_point,
    output logic            out_last
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_T     = 9'b000000100,
        ST_T2    = 9'b000001000,
        ST_T3    = 9'b000010000,
        ST_W     = 9'b000100000,
        ST_MAC   = 9'b001000000,
        ST_EMIT  = 9'b010000000,
        ST_FINAL = 9'b100000000
    } state_t;

    localparam int TP_W = crs_pkg::K_W + crs_pkg::STEP_W;

    state_t                           state_reg, state_next;
    crs_pkg::job_t                    job_reg;
    logic [crs_pkg::K_W-1:0]          i_reg, i_next;
    logic [1:0]                       m_reg, m_next;
    logic [crs_pkg::T_W-1:0]          t_reg;
    logic [2*crs_pkg::T_W-1:0]        t2_reg;
    logic [3*crs_pkg::T_W-1:0]        t3_reg;
    logic signed [crs_pkg::H_W-1:0]   h_reg [4];
    logic signed [crs_pkg::ACC_W-1:0] acc_reg [3];
    logic                             out_valid_reg;
    crs_pkg::point_t                  out_point_reg;
    logic                             out_last_reg;

    logic [crs_pkg::K_W-1:0]          k_eff;
    logic [TP_W-1:0]                  t_prod;
    logic [crs_pkg::T_W-1:0]          t_sat;
    logic                             out_free;
    logic                             out_load;
    crs_pkg::point_t                  out_point_next;
    logic                             out_last_next;
    logic signed [crs_pkg::W_W-1:0]   t1w, t2w, t3w;
    logic signed [crs_pkg::W_W-1:0]   w [4];
    logic signed [crs_pkg::H_W-1:0]   h_next [4];
    crs_pkg::point_t                  p_sel;
    logic signed [crs_pkg::H_W-1:0]   h_sel;
    logic signed [crs_pkg::PROD_W-1:0] prod [3];
    crs_pkg::point_t                  q_point;

    function automatic crs_pkg::coord_t round_sat(input logic signed [crs_pkg::ACC_W-1:0] a);
        logic signed [crs_pkg::ACC_W-1:0] r;
        logic signed [crs_pkg::Q_W-1:0]   q;
        logic signed [crs_pkg::Q_W-1:0]   hi;
        logic signed [crs_pkg::Q_W-1:0]   lo;
        r  = a + (crs_pkg::ACC_W'(1) <<< (crs_pkg::Q_SHIFT - 1));
        q  = r[crs_pkg::ACC_W-1:crs_pkg::Q_SHIFT];
        hi = crs_pkg::Q_W'({1'b0, {(crs_pkg::COORD_W-1){1'b1}}});
        lo = -hi - crs_pkg::Q_W'(1);
        if (q > hi)
        begin
            return hi[crs_pkg::COORD_W-1:0];
        end
        else if (q < lo)
        begin
            return lo[crs_pkg::COORD_W-1:0];
        end
        return q[crs_pkg::COORD_W-1:0];
    endfunction

    assign k_eff     = (cfg.samples == '0) ? crs_pkg::K_W'(1) : cfg.samples;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_point = out_point_reg;
    assign out_last  = out_last_reg;

    assign t_prod = TP_W'(i_reg) * TP_W'(cfg.step);
    assign t_sat  = (|t_prod[TP_W-1:crs_pkg::T_W]) ? crs_pkg::T_MAX
                                                   : t_prod[crs_pkg::T_W-1:0];

    // Doubled basis weights in Q.48, halved to Q.24 with round half up.
    always_comb
    begin
        t1w  = $signed({4'b0, t_reg, 32'b0});
        t2w  = $signed({4'b0, t2_reg, 16'b0});
        t3w  = $signed({4'b0, t3_reg});
        w[0] = -t3w + (t2w <<< 1) - t1w;
        w[1] = (t3w <<< 1) + t3w - (t2w <<< 2) - t2w
             + (crs_pkg::W_W'(2) <<< (3 * crs_pkg::T_W));
        w[2] = -(t3w <<< 1) - t3w + (t2w <<< 2) + t1w;
        w[3] = t3w - t2w;
        for (int m = 0; m < 4; m++)
        begin
            h_next[m] = crs_pkg::H_W'((w[m] + (crs_pkg::W_W'(1) <<< (crs_pkg::H_SHIFT - 1)))
                                      >>> crs_pkg::H_SHIFT);
        end
    end

    always_comb
    begin
        p_sel   = job_reg.p[m_reg];
        h_sel   = h_reg[m_reg];
        prod[0] = h_sel * p_sel.x;
        prod[1] = h_sel * p_sel.y;
        prod[2] = h_sel * p_sel.z;
        q_point.x = round_sat(acc_reg[0]);
        q_point.y = round_sat(acc_reg[1]);
        q_point.z = round_sat(acc_reg[2]);
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        m_next         = m_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_point_next = q_point;
        out_last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    i_next     = crs_pkg::K_W'(1);
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                out_point_next = job_reg.p[1];
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (k_eff > crs_pkg::K_W'(1))
                    begin
                        state_next = ST_T;
                    end
                    else
                    begin
                        state_next = job_reg.last ? ST_FINAL : ST_IDLE;
                    end
                end
            end
            ST_T:  state_next = ST_T2;
            ST_T2: state_next = ST_T3;
            ST_T3: state_next = ST_W;
            ST_W:
            begin
                m_next     = 2'd0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                m_next = m_reg + 2'd1;
                if (m_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    i_next   = i_reg + crs_pkg::K_W'(1);
                    if (i_reg == k_eff - crs_pkg::K_W'(1))
                    begin
                        state_next = job_reg.last ? ST_FINAL : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_T;
                    end
                end
            end
            ST_FINAL:
            begin
                out_point_next = job_reg.p[2];
                out_last_next  = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_T)
        begin
            t_reg <= t_sat;
        end
        if (state_reg == ST_T2)
        begin
            t2_reg <= t_reg * t_reg;
        end
        if (state_reg == ST_T3)
        begin
            t3_reg <= t2_reg * (3 * crs_pkg::T_W)'(t_reg);
        end
        if (state_reg == ST_W)
        begin
            for (int m = 0; m < 4; m++)
            begin
                h_reg[m] <= h_next[m];
            end
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        if (state_reg == ST_MAC)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= acc_reg[c] + crs_pkg::ACC_W'(prod[c]);
            end
        end
        if (out_load)
        begin
            out_point_reg <= out_point_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            m_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            m_reg     <= m_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> job_valid)
        else $error("job taken from an empty queue");
    a_mac_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_reg != 2'd0) |-> (state_reg == ST_MAC))
        else $error("weight index left running outside accumulation");
    a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T) |-> (i_reg < k_eff) && (i_reg != '0))
        else $error("sample index out of segment");
`endif

endmodule

@@ rtl/catmull_rom_spline_sampler.sv @@
// Uniform Catmull-Rom sampler for 3D points in signed Q16.16.
// Input channel: point_x/y/z and last_point, taken when in_valid is high
// and in_stall is low. Output channel: out_x/y/z and last_sample, taken
// when out_valid is high and out_stall is low.
// From the fourth point of a curve on, each point closes a segment and
// yields its start point, then samples_per_arc-1 curve samples; the point
// marked last also yields the final curve point with last_sample set.
// Configuration is to be written through cfg_write/cfg_index/cfg_data
// while idle; the block does not enforce this. A closing point passes the
// segment queue and the job register before its start point is output.
// Each curve sample takes three multiply steps in the back end for t,
// t^2 and t^3, one weight step, four multiply-accumulate steps over the
// control points and one output step. A two-entry segment queue lets the
// input side take further points while the back end is busy. A stalled
// receiver holds the output register and the back end waits; the input
// stalls once the queue is full. Reset empties the queue and the point
// history and restores samples_per_arc=16, step_fraction=4096.
module catmull_rom_spline_sampler
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [crs_pkg::COORD_W-1:0] point_x,
    input  logic signed [crs_pkg::COORD_W-1:0] point_y,
    input  logic signed [crs_pkg::COORD_W-1:0] point_z,
    input  logic                               last_point,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [crs_pkg::COORD_W-1:0] out_x,
    output logic signed [crs_pkg::COORD_W-1:0] out_y,
    output logic signed [crs_pkg::COORD_W-1:0] out_z,
    output logic                               last_sample
);

    crs_pkg::cfg_t   cfg_reg;
    crs_pkg::point_t in_point;
    crs_pkg::point_t out_point;
    crs_pkg::job_t   push_job;
    crs_pkg::job_t   job;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples <= crs_pkg::SAMPLES_RESET;
            cfg_reg.step    <= crs_pkg::STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                crs_pkg::CFG_SAMPLES: cfg_reg.samples <= cfg_data[crs_pkg::K_W-1:0];
                crs_pkg::CFG_STEP:    cfg_reg.step    <= cfg_data[crs_pkg::STEP_W-1:0];
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign in_point.x = point_x;
    assign in_point.y = point_y;
    assign in_point.z = point_z;
    assign out_x      = out_point.x;
    assign out_y      = out_point.y;
    assign out_z      = out_point.z;

    crs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_point   (in_point),
        .in_last    (last_point),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    crs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .job_valid (job_valid),
        .job       (job)
    );

    crs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_point (out_point),
        .out_last  (last_sample)
    );

endmodule
